// ===== rtl/weno5ld_pkg.sv =====
// Package for the WENO5-JS line derivative block.
// Shared widths, register indexes, the configuration struct and the back-end state codes.
// No dependencies.
package weno5ld_pkg;

	localparam int SAMPLE_WIDTH_DEF = 32;

	// configuration register map
	localparam int INV_W     = 24;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_UPWIND_BIAS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 1'b1;
	localparam logic [INV_W-1:0]     INV_RESET       = 24'd65536;

	// arithmetic formats
	localparam int INV_FRAC = 16;
	localparam int WEIGHT_Q = 20;
	localparam int RED_BITS = 15;
	localparam int SM_W     = 20;
	localparam int S12_W    = 40;
	localparam int EPS_W    = 16;
	localparam int RHO_W    = WEIGHT_Q + 1;
	localparam int A_W      = 43;

	// epsilon: 12*m^2/10^6 = ((3*m^2) >> 4) / 15625, by reciprocal multiply
	localparam int EZ_W      = 28;
	localparam int EPS_PRE   = 4;
	localparam int EPS_RCP_W = 29;
	localparam int EPS_SHIFT = 42;
	localparam logic [EPS_RCP_W-1:0] EPS_RECIP = 29'd281474977;

	// shared divider
	localparam int NUM_W = 64;
	localparam int DEN_W = 44;
	localparam int CNT_W = 7;

	typedef struct packed {
		logic             upwind_bias;
		logic [INV_W-1:0] inverse_spacing;
	} cfg_t;

	typedef enum logic [4:0] {
		BK_IDLE,
		BK_DIFF,
		BK_MAX,
		BK_NORM,
		BK_SMOOTH,
		BK_EPS,
		BK_BMIN,
		BK_RHO_GO,
		BK_RHO_WAIT,
		BK_AMUL,
		BK_SUM,
		BK_W_GO,
		BK_W_WAIT,
		BK_CDIV,
		BK_ACC_LO,
		BK_ACC_HI,
		BK_SC_LO,
		BK_SC_HI,
		BK_OUT
	} back_state_t;

endpackage

// ===== rtl/weno5_line_derivative.sv =====
// The front end takes samples and issues window jobs; the back end computes each derivative
// with six serial 64-bit divisions on the one shared divider, plus the normalizing shift
// of one bit at a time.
// Throughput: one derivative per back-end pass; a sample that closes a line yields up to three.
// Reset (arst_n low) clears row state, queue and output valid and loads the register defaults.
module weno5_line_derivative #(
	parameter int SAMPLE_WIDTH = weno5ld_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [SAMPLE_WIDTH-1:0]           sample,
	input  logic                              first_of_row,
	input  logic                              last_of_row,
	input  logic                              in_valid,
	output logic                              in_stall,
	output logic [SAMPLE_WIDTH-1:0]           derivative,
	output logic                              row_done,
	output logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [weno5ld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [weno5ld_pkg::INV_W-1:0]     cfg_data
);
	import weno5ld_pkg::*;

	localparam int JOB_W = 6 * SAMPLE_WIDTH + 1;

	cfg_t             cfg_q;
	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	logic [JOB_W-1:0] q_data;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upwind_bias     <= 1'b0;
			cfg_q.inverse_spacing <= INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_UPWIND_BIAS: cfg_q.upwind_bias     <= cfg_data[0];
				REG_INV_SPACING: cfg_q.inverse_spacing <= cfg_data;
				default: ;
			endcase
		end
	end

	weno5ld_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.first_of_row (first_of_row),
		.last_of_row  (last_of_row),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	weno5ld_queue #(.WIDTH(JOB_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_data)
	);

	weno5ld_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.derivative (derivative),
		.row_done   (row_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

// ===== rtl/weno5ld_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on weno5ld_pkg for the operand widths.
module weno5ld_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [weno5ld_pkg::NUM_W-1:0] num,
	input  logic [weno5ld_pkg::DEN_W-1:0] den,
	output logic                          busy,
	output logic                          done,
	output logic [weno5ld_pkg::NUM_W-1:0] quot
);
	import weno5ld_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// trial subtract of the next numerator bit
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/weno5ld_queue.sv =====
// Two-entry job queue between the window front end and the arithmetic back end.
// Imports weno5ld_pkg but uses none of it; holds raw job words.
module weno5ld_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);
	import weno5ld_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop)  rd_q <= rd_q + PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

	// store the entry
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

// ===== rtl/weno5ld_front.sv =====
// Front end: accepts samples, keeps the padded six-sample window and row position,
// and issues one window job per derivative. Depends on weno5ld_pkg.
module weno5ld_front #(
	parameter int SAMPLE_WIDTH = weno5ld_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [SAMPLE_WIDTH-1:0]   sample,
	input  logic                      first_of_row,
	input  logic                      last_of_row,
	input  logic                      in_valid,
	output logic                      in_stall,
	output logic                      push,
	output logic [6*SAMPLE_WIDTH:0]   push_data,
	input  logic                      q_full
);
	import weno5ld_pkg::*;

	localparam int W = SAMPLE_WIDTH;
	localparam logic [1:0] ROW_NONE = 2'd0;
	localparam logic [1:0] ROW_ONE  = 2'd1;
	localparam logic [1:0] ROW_MANY = 2'd2;
	localparam logic [1:0] PADS_NONE = 2'd0;
	localparam logic [1:0] PADS_ONE  = 2'd1;
	localparam logic [1:0] PADS_TWO  = 2'd2;

	logic [W-1:0] win_q [6];
	logic [W-1:0] x_q;
	logic [1:0]   rowpos_q;
	logic         emit_q;
	logic [1:0]   pads_q;
	logic         busy;
	logic         accept;
	logic         start;
	logic         prior_many;
	logic [W-1:0] shifted [6];

	assign busy       = emit_q || (pads_q != PADS_NONE);
	assign in_stall   = busy;
	assign accept     = in_valid && !busy;
	assign start      = first_of_row || (rowpos_q == ROW_NONE);
	assign prior_many = (rowpos_q != ROW_NONE) && (rowpos_q != ROW_ONE);
	assign push       = busy && !q_full;

	// window with the held end sample shifted in, for edge padding
	always_comb begin
		for (int k = 0; k < 5; k++) shifted[k] = win_q[k+1];
		shifted[5] = x_q;
	end

	// pack the job: current window, or the padded one
	always_comb begin
		for (int k = 0; k < 6; k++)
			push_data[k*W +: W] = emit_q ? win_q[k] : shifted[k];
		push_data[6*W] = !emit_q && (pads_q == PADS_ONE);
	end

	// row position and pending jobs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowpos_q <= ROW_NONE;
			emit_q   <= 1'b0;
			pads_q   <= PADS_NONE;
		end else if (accept) begin
			emit_q   <= !start && prior_many;
			pads_q   <= last_of_row ? (start ? PADS_ONE : PADS_TWO) : PADS_NONE;
			rowpos_q <= last_of_row ? ROW_NONE : (start ? ROW_ONE : ROW_MANY);
		end else if (push) begin
			if (emit_q) emit_q <= 1'b0;
			else        pads_q <= pads_q - 2'd1;
		end
	end

	// fill or shift the window
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample;
			for (int k = 0; k < 5; k++) win_q[k] <= start ? sample : win_q[k+1];
			win_q[5] <= sample;
		end else if (push && !emit_q) begin
			for (int k = 0; k < 6; k++) win_q[k] <= shifted[k];
		end
	end

endmodule

// ===== rtl/weno5ld_back.sv =====
// Back end: WENO5-JS weights and blend for one window job, on a sequencer around
// the shared divider and a split multiplier. Depends on weno5ld_pkg and weno5ld_div.
module weno5ld_back #(
	parameter int SAMPLE_WIDTH = weno5ld_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  weno5ld_pkg::cfg_t         cfg,
	input  logic                      q_valid,
	input  logic [6*SAMPLE_WIDTH:0]   q_data,
	output logic                      q_pop,
	output logic [SAMPLE_WIDTH-1:0]   derivative,
	output logic                      row_done,
	output logic                      out_valid,
	input  logic                      out_stall
);
	import weno5ld_pkg::*;

	localparam int W    = SAMPLE_WIDTH;
	localparam int VW   = W + 1;
	localparam int MAGW = W + 1;
	localparam int QW   = W + 6;
	localparam int QMW  = W + 5;
	localparam int CMW  = W + 2;
	localparam int ACW  = W + 4;
	localparam int MW   = W + 3;
	localparam int MH   = (MW + 1) / 2;
	localparam int MHI  = MW - MH;
	localparam int PW   = MW + INV_W;
	localparam int YW   = QMW - 1;
	localparam int DH   = ((YW + 3) / 4) * 2;
	localparam logic [DH-1:0] K3 = DH'(((64'd1 << DH) - 64'd1) / 64'd3);
	localparam logic [DH-1:0] M3 = DH'(((64'd1 << (DH + 1)) + 64'd1) / 64'd3);
	localparam logic [1:0] LAST_K = 2'd2;
	localparam logic [PW-1:0] MAXP = (PW'(1) << (W - 1)) - PW'(1);
	localparam logic [PW-1:0] MAXN = PW'(1) << (W - 1);

	back_state_t state_q, state_d;
	logic [1:0]  k_q, k_d;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] div_quot;
	logic        out_load;

	// job and datapath registers
	logic [6*W-1:0]          win_q;
	logic                    rd_q;
	logic signed [VW-1:0]    v_q [5];
	logic [MAGW-1:0]         vmag_q [5];
	logic                    vneg_q [5];
	logic [MAGW-1:0]         m_q;
	logic [S12_W-1:0]        s12_q [3];
	logic [S12_W-1:0]        b_q [3];
	logic [S12_W-1:0]        bmin_q;
	logic [EZ_W-1:0]         ez_q;
	logic [QMW-1:0]          qmag_q [3];
	logic                    qneg_q [3];
	logic [RHO_W-1:0]        rho_q;
	logic [A_W-1:0]          a_q [3];
	logic [DEN_W-1:0]        sum_q;
	logic [RHO_W-1:0]        w_q [3];
	logic [CMW-1:0]          cmag_q [3];
	logic signed [ACW-1:0]   acc_q;
	logic [PW-1:0]           prod_q;
	logic [W-1:0]            res_q;
	logic                    out_valid_q;
	logic [W-1:0]            deriv_q;
	logic                    rdo_q;

	// combinational terms
	logic signed [W-1:0]     smp [6];
	logic signed [VW-1:0]    dif [5];
	logic [MAGW-1:0]         vabs [5];
	logic [MAGW-1:0]         vmax;
	logic signed [SM_W-1:0]  r_e [5];
	logic signed [SM_W-1:0]  t_s [3];
	logic signed [SM_W-1:0]  d_s [3];
	logic signed [2*SM_W-1:0] tsq [3];
	logic signed [2*SM_W-1:0] dsq [3];
	logic [S12_W-1:0]        s12 [3];
	logic [29:0]             msq;
	logic signed [QW-1:0]    v_e [5];
	logic signed [QW-1:0]    q_s [3];
	logic [EZ_W+EPS_RCP_W-1:0] eprod;
	logic [EPS_W-1:0]        eps;
	logic [S12_W-1:0]        bmin;
	logic [2*RHO_W-1:0]      rsq;
	logic [2:0]              gain;
	logic [YW-1:0]           chalf;
	logic [DH:0]             csum;
	logic [2*DH:0]           cfrac_p;
	logic [CMW-1:0]          cdiv;
	logic [MW-1:0]           mul_a;
	logic [INV_W-1:0]        mul_b;
	logic [MH+INV_W-1:0]     plo;
	logic [MHI+INV_W-1:0]    phi;
	logic [PW-1:0]           full;
	logic [PW-1:0]           term;
	logic [PW-1:0]           p_sc;
	logic [PW-1:0]           p_sat;
	logic                    acc_neg;
	logic [MW-1:0]           am;

	weno5ld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// differences of neighbouring samples; the upwind bias orients them when they are loaded
	always_comb begin
		for (int k = 0; k < 6; k++) smp[k] = $signed(win_q[k*W +: W]);
		for (int k = 0; k < 5; k++) dif[k] = VW'(smp[k+1]) - VW'(smp[k]);
	end

	// magnitudes and their maximum
	always_comb begin
		vmax = '0;
		for (int k = 0; k < 5; k++) begin
			vabs[k] = v_q[k][VW-1] ? MAGW'(-v_q[k]) : MAGW'(v_q[k]);
			if (vabs[k] > vmax) vmax = vabs[k];
		end
	end

	// smoothness indicators on reduced differences, and the candidates
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			r_e[k] = vneg_q[k] ? -$signed(SM_W'(vmag_q[k][RED_BITS-1:0]))
			                   :  $signed(SM_W'(vmag_q[k][RED_BITS-1:0]));
			v_e[k] = QW'(v_q[k]);
		end
		t_s[0] = r_e[0] - (r_e[1] <<< 1) + r_e[2];
		d_s[0] = r_e[0] - (r_e[1] <<< 2) + (r_e[2] <<< 1) + r_e[2];
		t_s[1] = r_e[1] - (r_e[2] <<< 1) + r_e[3];
		d_s[1] = r_e[1] - r_e[3];
		t_s[2] = r_e[2] - (r_e[3] <<< 1) + r_e[4];
		d_s[2] = (r_e[2] <<< 1) + r_e[2] - (r_e[3] <<< 2) + r_e[4];
		for (int k = 0; k < 3; k++) begin
			tsq[k] = t_s[k] * t_s[k];
			dsq[k] = d_s[k] * d_s[k];
			s12[k] = S12_W'($unsigned(tsq[k])) * S12_W'(13)
			       + S12_W'($unsigned(dsq[k])) * S12_W'(3);
		end
		msq = m_q[RED_BITS-1:0] * m_q[RED_BITS-1:0];
		q_s[0] = (v_e[0] <<< 1) - ((v_e[1] <<< 3) - v_e[1])
		       + (v_e[2] <<< 3) + (v_e[2] <<< 1) + v_e[2];
		q_s[1] = -v_e[1] + (v_e[2] <<< 2) + v_e[2] + (v_e[3] <<< 1);
		q_s[2] = (v_e[2] <<< 1) + (v_e[3] <<< 2) + v_e[3] - v_e[4];
	end

	// epsilon floor, smallest indicator, weight gain
	always_comb begin
		eprod = (EZ_W+EPS_RCP_W)'(ez_q) * (EZ_W+EPS_RCP_W)'(EPS_RECIP);
		eps   = (eprod[EZ_W+EPS_RCP_W-1:EPS_SHIFT] == '0) ? EPS_W'(1)
		      : EPS_W'(eprod[EZ_W+EPS_RCP_W-1:EPS_SHIFT]);
		bmin = b_q[0];
		for (int k = 1; k < 3; k++) if (b_q[k] < bmin) bmin = b_q[k];
		rsq = rho_q * rho_q;
		case (k_q)
			2'd0:    gain = cfg.upwind_bias ? 3'd3 : 3'd1;
			2'd1:    gain = 3'd6;
			2'd2:    gain = cfg.upwind_bias ? 3'd1 : 3'd3;
			default: gain = 3'd0;
		endcase
	end

	// candidate over six: halve, then split so that 2^DH = 3*K3 + 1 folds the high part
	always_comb begin
		chalf   = qmag_q[k_q][QMW-1:1];
		csum    = (DH+1)'(chalf[YW-1:DH]) + (DH+1)'(chalf[DH-1:0]);
		cfrac_p = (2*DH+1)'(csum) * (2*DH+1)'(M3);
		cdiv    = CMW'(CMW'(chalf[YW-1:DH]) * CMW'(K3)) + CMW'(cfrac_p[2*DH:DH+1]);
	end

	// divider operands
	always_comb begin
		case (state_q)
			BK_RHO_GO: begin
				div_num = NUM_W'(bmin_q) << WEIGHT_Q;
				div_den = DEN_W'(b_q[k_q]);
			end
			default: begin
				div_num = NUM_W'(a_q[k_q]) << WEIGHT_Q;
				div_den = sum_q;
			end
		endcase
	end

	// split multiplier: blend term or spacing scale
	always_comb begin
		acc_neg = acc_q[ACW-1];
		am      = acc_neg ? MW'(-acc_q) : MW'(acc_q);
		if (state_q == BK_SC_LO || state_q == BK_SC_HI) begin
			mul_a = am;
			mul_b = cfg.inverse_spacing;
		end else begin
			mul_a = MW'(cmag_q[k_q]);
			mul_b = INV_W'(w_q[k_q]);
		end
		plo  = mul_a[MH-1:0] * mul_b;
		phi  = mul_a[MW-1:MH] * mul_b;
		full = prod_q + (PW'(phi) << MH);
		term = full >> WEIGHT_Q;
		p_sc = full >> INV_FRAC;
		if (acc_neg) p_sat = (p_sc > MAXN) ? MAXN : p_sc;
		else         p_sat = (p_sc > MAXP) ? MAXP : p_sc;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE: if (q_valid) begin
				q_pop   = 1'b1;
				state_d = BK_DIFF;
			end
			BK_DIFF: state_d = BK_MAX;
			BK_MAX:  state_d = BK_NORM;
			BK_NORM: if (m_q[MAGW-1:RED_BITS] == '0) state_d = BK_SMOOTH;
			BK_SMOOTH: state_d = BK_EPS;
			BK_EPS: state_d = BK_BMIN;
			BK_BMIN: begin
				k_d     = '0;
				state_d = BK_RHO_GO;
			end
			BK_RHO_GO: begin
				div_start = 1'b1;
				state_d   = BK_RHO_WAIT;
			end
			BK_RHO_WAIT: if (div_done) state_d = BK_AMUL;
			BK_AMUL: begin
				if (k_q == LAST_K) begin
					k_d     = '0;
					state_d = BK_SUM;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = BK_RHO_GO;
				end
			end
			BK_SUM: state_d = BK_W_GO;
			BK_W_GO: begin
				div_start = 1'b1;
				state_d   = BK_W_WAIT;
			end
			BK_W_WAIT: if (div_done) begin
				if (k_q == LAST_K) begin
					k_d     = '0;
					state_d = BK_CDIV;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = BK_W_GO;
				end
			end
			BK_CDIV: begin
				if (k_q == LAST_K) begin
					k_d     = '0;
					state_d = BK_ACC_LO;
				end else begin
					k_d     = k_q + 2'd1;
				end
			end
			BK_ACC_LO: state_d = BK_ACC_HI;
			BK_ACC_HI: begin
				if (k_q == LAST_K) begin
					k_d     = '0;
					state_d = BK_SC_LO;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = BK_ACC_LO;
				end
			end
			BK_SC_LO: state_d = BK_SC_HI;
			BK_SC_HI: state_d = BK_OUT;
			BK_OUT: if (!out_valid_q || !out_stall) begin
				out_load = 1'b1;
				state_d  = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath registers, loaded per step
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: if (q_valid) begin
				win_q <= q_data[6*W-1:0];
				rd_q  <= q_data[6*W];
			end
			BK_DIFF: begin
				for (int k = 0; k < 5; k++) v_q[k] <= cfg.upwind_bias ? dif[4-k] : dif[k];
			end
			BK_MAX: begin
				for (int k = 0; k < 5; k++) begin
					vmag_q[k] <= vabs[k];
					vneg_q[k] <= v_q[k][VW-1];
				end
				m_q <= vmax;
			end
			BK_NORM: if (m_q[MAGW-1:RED_BITS] != '0) begin
				m_q <= m_q >> 1;
				for (int k = 0; k < 5; k++) vmag_q[k] <= vmag_q[k] >> 1;
			end
			BK_SMOOTH: begin
				for (int k = 0; k < 3; k++) begin
					s12_q[k]  <= s12[k];
					qneg_q[k] <= q_s[k][QW-1];
					qmag_q[k] <= q_s[k][QW-1] ? QMW'(-q_s[k]) : QMW'(q_s[k]);
				end
				ez_q <= EZ_W'(((32'(msq) << 1) + 32'(msq)) >> EPS_PRE);
			end
			BK_EPS: begin
				for (int k = 0; k < 3; k++) b_q[k] <= s12_q[k] + S12_W'(eps);
			end
			BK_BMIN: begin
				bmin_q <= bmin;
				acc_q  <= '0;
			end
			BK_RHO_WAIT: if (div_done) rho_q <= div_quot[RHO_W-1:0];
			BK_AMUL: a_q[k_q] <= A_W'(rsq) * A_W'(gain);
			BK_SUM: sum_q <= DEN_W'(a_q[0]) + DEN_W'(a_q[1]) + DEN_W'(a_q[2]);
			BK_W_WAIT: if (div_done) w_q[k_q] <= div_quot[RHO_W-1:0];
			BK_CDIV: cmag_q[k_q] <= cdiv;
			BK_ACC_LO: prod_q <= PW'(plo);
			BK_ACC_HI: begin
				if (qneg_q[k_q]) acc_q <= acc_q - $signed(ACW'(term));
				else             acc_q <= acc_q + $signed(ACW'(term));
			end
			BK_SC_LO: prod_q <= PW'(plo);
			BK_SC_HI: res_q <= acc_neg ? W'(PW'(0) - p_sat) : W'(p_sat);
			BK_OUT: if (out_load) begin
				deriv_q <= res_q;
				rdo_q   <= rd_q;
			end
			default: ;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)             out_valid_q <= 1'b0;
		else if (out_load)       out_valid_q <= 1'b1;
		else if (!out_stall)     out_valid_q <= 1'b0;
	end

	assign derivative = deriv_q;
	assign row_done   = rdo_q;
	assign out_valid  = out_valid_q;

	// reduced maximum is below the indicator range once normalization ends
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SMOOTH |-> m_q[MAGW-1:RED_BITS] == '0)
		else $error("normalization left the maximum too wide");

	// normalized weights never exceed one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_W_WAIT && div_done) |-> div_quot <= (NUM_W'(1) << WEIGHT_Q))
		else $error("weight above one");

	// the divider is idle whenever a division is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// a blocked result holds the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_OUT && out_valid_q && out_stall) |=> state_q == BK_OUT)
		else $error("result dropped while output stalled");

	// stencil counter stays within the three candidates
	assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= LAST_K)
		else $error("stencil counter out of range");

endmodule

// ===== bench/tb_weno5_line_derivative.sv =====
// Self-checking bench for weno5_line_derivative: streams sample lines, predicts
// every WENO5-JS derivative and compares it with the DUT output under random idling.
// Depends on rtl/weno5ld_pkg.sv and rtl/weno5_line_derivative.sv.
`timescale 1ns / 1ps

module tb_weno5_line_derivative;
	import weno5ld_pkg::*;

	localparam int SW = 32;
	localparam longint LIMIT = 3000000;
	localparam int DRAIN = 900;

	typedef struct {
		logic [SW-1:0] sample;
		logic          first;
		logic          last;
	} sample_item_t;

	typedef struct {
		logic [SW-1:0] derivative;
		logic          row_done;
	} deriv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [SW-1:0] sample = '0;
	logic first_of_row = 1'b0;
	logic last_of_row = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SW-1:0] derivative;
	logic row_done;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [INV_W-1:0] cfg_data = '0;

	weno5_line_derivative dut (
		.clk(clk), .arst_n(arst_n),
		.sample(sample), .first_of_row(first_of_row), .last_of_row(last_of_row),
		.in_valid(in_valid), .in_stall(in_stall),
		.derivative(derivative), .row_done(row_done),
		.out_valid(out_valid), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	longint win [6];
	int line_pos;
	logic bias_m;
	logic [INV_W-1:0] inv_m;

	sample_item_t pending_samples[$];
	deriv_t expected_derivs[$];
	int errors = 0;
	int n_items = 0;
	bit calm = 0;
	bit long_hold_go = 0;

	function automatic longint unsigned mag(longint x);
		return x < 0 ? longint'(-x) : longint'(x);
	endfunction

	function automatic longint reduce_mag(longint x, int s);
		longint m;
		m = longint'(mag(x) >> s);
		return x < 0 ? -m : m;
	endfunction

	function automatic longint unsigned smooth12(longint a, longint b, longint c, longint d);
		longint t;
		t = a - 2 * b + c;
		return longint'(13 * t * t + 3 * d * d);
	endfunction

	// compute one derivative from the current window and configuration
	function automatic logic [SW-1:0] weno_derive();
		longint d [5];
		longint v [5];
		longint r [5];
		longint q [3];
		longint unsigned g [3];
		longint unsigned b [3];
		longint unsigned a [3];
		longint unsigned m, bmin, sum, eps, rho, am;
		longint acc, w, c, ch, cl;
		logic [127:0] p;
		int s;
		m = 0; sum = 0; acc = 0; s = 0;
		for (int k = 0; k < 5; k++) d[k] = win[k+1] - win[k];
		for (int k = 0; k < 5; k++) v[k] = bias_m ? d[4-k] : d[k];
		g[0] = bias_m ? 3 : 1; g[1] = 6; g[2] = bias_m ? 1 : 3;
		for (int k = 0; k < 5; k++) if (mag(v[k]) > m) m = mag(v[k]);
		while ((m >> s) >= (64'd1 << 15)) s++;
		for (int k = 0; k < 5; k++) r[k] = reduce_mag(v[k], s);
		m = m >> s;
		eps = (12 * m * m) / 1000000;
		if (eps < 1) eps = 1;
		b[0] = smooth12(r[0], r[1], r[2], r[0] - 4 * r[1] + 3 * r[2]) + eps;
		b[1] = smooth12(r[1], r[2], r[3], r[1] - r[3]) + eps;
		b[2] = smooth12(r[2], r[3], r[4], 3 * r[2] - 4 * r[3] + r[4]) + eps;
		bmin = b[0];
		for (int k = 1; k < 3; k++) if (b[k] < bmin) bmin = b[k];
		for (int k = 0; k < 3; k++) begin
			rho = (bmin << WEIGHT_Q) / b[k];
			a[k] = g[k] * rho * rho;
			sum += a[k];
		end
		q[0] = 2 * v[0] - 7 * v[1] + 11 * v[2];
		q[1] = -v[1] + 5 * v[2] + 2 * v[3];
		q[2] = 2 * v[2] + 5 * v[3] - v[4];
		for (int k = 0; k < 3; k++) begin
			w = longint'((a[k] << WEIGHT_Q) / sum);
			c = q[k] / 6;
			ch = c / (64'sd1 << WEIGHT_Q);
			cl = c - ch * (64'sd1 << WEIGHT_Q);
			acc += w * ch + (w * cl) / (64'sd1 << WEIGHT_Q);
		end
		if (inv_m == 0) return '0;
		am = mag(acc);
		p = ({64'd0, am} * {104'd0, inv_m}) >> INV_FRAC;
		if (acc >= 0) begin
			if (p > 128'h7FFF_FFFF) p = 128'h7FFF_FFFF;
			return p[SW-1:0];
		end
		if (p > 128'h8000_0000) p = 128'h8000_0000;
		return -p[SW-1:0];
	endfunction

	function automatic void shift_window(longint x);
		for (int k = 0; k < 5; k++) win[k] = win[k+1];
		win[5] = x;
	endfunction

	// advance the line state by one accepted sample and queue its derivatives
	function automatic void take_sample(sample_item_t it);
		longint x;
		int prior, pads;
		deriv_t e;
		x = longint'($signed(it.sample));
		if (it.first || line_pos == 0) begin
			for (int k = 0; k < 6; k++) win[k] = x;
			prior = 0;
		end else begin
			prior = line_pos >= 2 ? 2 : line_pos;
			shift_window(x);
		end
		if (prior >= 2) begin
			e.derivative = weno_derive(); e.row_done = 1'b0;
			expected_derivs.push_back(e);
		end
		if (it.last) begin
			pads = prior == 0 ? 1 : 2;
			for (int k = 0; k < pads; k++) begin
				shift_window(x);
				e.derivative = weno_derive();
				e.row_done = (k + 1 == pads);
				expected_derivs.push_back(e);
			end
			line_pos = 0;
		end else begin
			line_pos = prior == 0 ? 1 : 2;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive samples from the pending queue
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		sample_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) take_sample('{sample, first_of_row, last_of_row});
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					it = pending_samples.pop_front();
					sample <= it.sample;
					first_of_row <= it.first;
					last_of_row <= it.last;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check each derivative transfer and pick the next stall
	int out_gap;
	int hold_cnt;
	bit long_done;
	always @(posedge clk or negedge arst_n) begin
		deriv_t e;
		int r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0; hold_cnt = 0; long_done = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_derivs.size() == 0) begin
					$display("%0t: unexpected derivative %h row_done %b", $time,
						derivative, row_done);
					errors++;
				end else begin
					e = expected_derivs.pop_front();
					if (derivative !== e.derivative) begin
						$display("%0t: derivative expected %h actual %h", $time,
							e.derivative, derivative);
						errors++;
					end
					if (row_done !== e.row_done) begin
						$display("%0t: row_done expected %b actual %b", $time,
							e.row_done, row_done);
						errors++;
					end
				end
			end
			if (long_hold_go && !long_done) begin
				long_done = 1;
				hold_cnt = 4000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!calm) begin
					r = $urandom_range(0, 99);
					if (r < 25) out_gap = $urandom_range(1, 3);
					else if (r < 30) out_gap = $urandom_range(20, 400);
				end
			end
		end
	end

	// end the run if it hangs
	longint cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[weno5_line_derivative] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [INV_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_UPWIND_BIAS) bias_m = val[0];
		else inv_m = val;
	endtask

	task automatic add_sample(logic [SW-1:0] s, logic f, logic l);
		pending_samples.push_back('{s, f, l});
		n_items++;
	endtask

	// one well-formed line; smooth lines take mostly small steps, rough ones full-range values
	task automatic add_line(int n, bit rough);
		logic [SW-1:0] s;
		s = $urandom;
		for (int k = 0; k < n; k++) begin
			if (rough || $urandom_range(0, 9) == 0) s = $urandom;
			else s = s + SW'($signed($urandom_range(0, 8192)) - 4096);
			add_sample(s, k == 0, k == n - 1);
		end
	endtask

	// hold the sender until every derivative is out and the back end is quiet
	task automatic drain();
		while (pending_samples.size() > 0 || in_valid) @(posedge clk);
		while (expected_derivs.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_part(int count);
		int r;
		while (n_items < count) begin
			r = $urandom_range(0, 99);
			if (r < 80) add_line($urandom_range(1, 8), $urandom_range(0, 3) == 0);
			else if (r < 90) add_sample($urandom, 1'($urandom), 1'($urandom));
			else begin
				// broken line: no opening mark, or a restart inside it
				add_sample($urandom, 1'b0, 1'b0);
				add_sample($urandom, 1'($urandom), 1'b0);
				add_sample($urandom, 1'b1, 1'b0);
				add_sample($urandom, 1'b0, 1'($urandom));
			end
		end
	endtask

	initial begin
		for (int k = 0; k < 6; k++) win[k] = 0;
		line_pos = 0;
		bias_m = 1'b0;
		inv_m = INV_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, short lines and mark corner cases
		add_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
		add_sample(32'h0001_0000, 1'b1, 1'b0);
		add_sample(32'h0003_0000, 1'b0, 1'b1);
		add_sample(32'h1234_5678, 1'b0, 1'b0);
		add_sample(32'h1235_0000, 1'b0, 1'b0);
		add_sample(32'h0000_0000, 1'b1, 1'b0);
		add_sample(32'h0002_0000, 1'b0, 1'b0);
		add_sample(32'h0008_0000, 1'b0, 1'b0);
		add_sample(32'h0004_0000, 1'b0, 1'b1);
		drain();

		// directed: largest spacing with extreme swings to hit saturation
		write_reg(REG_INV_SPACING, 24'hFF_FFFF);
		write_reg(REG_UPWIND_BIAS, 24'd1);
		add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
		add_sample(32'h8000_0000, 1'b0, 1'b0);
		add_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_sample(32'h8000_0000, 1'b0, 1'b0);
		add_sample(32'h7FFF_FFFF, 1'b0, 1'b1);
		add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
		add_sample(32'h0000_0000, 1'b0, 1'b1);
		drain();

		// directed: zero spacing
		write_reg(REG_INV_SPACING, 24'd0);
		write_reg(REG_UPWIND_BIAS, 24'd0);
		add_sample(32'h8000_0000, 1'b1, 1'b0);
		add_sample(32'h4000_0000, 1'b0, 1'b0);
		add_sample(32'h7FFF_FFFF, 1'b0, 1'b1);
		drain();

		// random phases over several settings; one of them under a long receiver hold
		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			case (ph)
				0: write_reg(REG_INV_SPACING, 24'd65536);
				1: write_reg(REG_INV_SPACING, 24'd1);
				2: write_reg(REG_INV_SPACING, INV_W'($urandom_range(0, 24'hFF_FFFF)));
				3: write_reg(REG_INV_SPACING, 24'hFF_FFFF);
				default: write_reg(REG_INV_SPACING,
					INV_W'($urandom_range(1 << 12, 1 << 20)));
			endcase
			write_reg(REG_UPWIND_BIAS, INV_W'(ph[0]));
			if (ph == 1) long_hold_go = 1;
			random_part(n_items + 45);
			drain();
		end
		calm = 0;

		if (expected_derivs.size() > 0) errors++;
		if (errors == 0) begin
			$display("[weno5_line_derivative] OK");
		end else begin
			$display("[weno5_line_derivative] ERROR");
		end
		$finish;
	end

endmodule

// ===== weno5_line_derivative.f =====
rtl/weno5ld_pkg.sv
rtl/weno5ld_div.sv
rtl/weno5ld_queue.sv
rtl/weno5ld_front.sv
rtl/weno5ld_back.sv
rtl/weno5_line_derivative.sv
bench/tb_weno5_line_derivative.sv
